### rtl/tec_pkg.sv
// ----------------------------------------------------------------------------
// tec_pkg
// Shared types and constants for the text encoding classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package tec_pkg;

	localparam int unsigned ClassWidth = 3;
	localparam int unsigned AccWidth   = 21;

	// Result class codes
	localparam logic [ClassWidth-1:0] CLS_UTF8     = 3'd0;
	localparam logic [ClassWidth-1:0] CLS_UTF8_BOM = 3'd1;
	localparam logic [ClassWidth-1:0] CLS_U16LE    = 3'd2;
	localparam logic [ClassWidth-1:0] CLS_U16BE    = 3'd3;
	localparam logic [ClassWidth-1:0] CLS_OTHER    = 3'd4;

	// Byte-order marks, first two bytes packed high-first
	localparam logic [15:0] BOM_UTF8_HEAD = 16'hEFBB;
	localparam logic [7:0]  BOM_UTF8_TAIL = 8'hBF;
	localparam logic [15:0] BOM_U16LE     = 16'hFFFE;
	localparam logic [15:0] BOM_U16BE     = 16'hFEFF;

	// Validation limits
	localparam logic [7:0]          LEAD2_MIN   = 8'hC2;
	localparam logic [AccWidth-1:0] CP3_MIN     = 21'h000800;
	localparam logic [AccWidth-1:0] SURR_LO     = 21'h00D800;
	localparam logic [AccWidth-1:0] SURR_HI     = 21'h00DFFF;
	localparam logic [AccWidth-1:0] CP4_MIN     = 21'h010000;
	localparam logic [AccWidth-1:0] CP4_MAX     = 21'h10FFFF;

	// Continuation counts of the open sequence
	localparam logic [1:0] SEQ_TWO   = 2'd1;
	localparam logic [1:0] SEQ_THREE = 2'd2;
	localparam logic [1:0] SEQ_FOUR  = 2'd3;

	typedef struct packed {
		logic [15:0]         lead;    // first byte in [15:8], second in [7:0]
		logic [1:0]          seen;    // bytes taken, saturating at three
		logic [1:0]          cont;    // continuation bytes still owed
		logic [1:0]          seqlen;  // continuation count of open sequence
		logic [AccWidth-1:0] acc;     // value of the open sequence
		logic                inv;     // sticky validation failure
	} tec_state_t;

endpackage

`default_nettype wire

### rtl/tec_step.sv
// ----------------------------------------------------------------------------
// tec_step
// Next-state and class logic for one byte of text.
// ----------------------------------------------------------------------------
`default_nettype none

module tec_step (
	input  wire tec_pkg::tec_state_t              cur,
	input  wire logic [7:0]                       data_byte,
	output tec_pkg::tec_state_t                   nxt,
	output logic [tec_pkg::ClassWidth-1:0]        encoding_class
);

	logic [tec_pkg::AccWidth-1:0] acc_shift;
	logic [1:0]                   cont_dec;

	assign acc_shift = {cur.acc[tec_pkg::AccWidth-7:0], data_byte[5:0]};
	assign cont_dec  = cur.cont - 2'd1;

	always_comb begin
		nxt = cur;

		// mark capture
		case (cur.seen)
			2'd0: nxt.lead = {data_byte, 8'h00};
			2'd1: nxt.lead = {cur.lead[15:8], data_byte};
			2'd2: begin
				if (cur.lead == tec_pkg::BOM_UTF8_HEAD && data_byte != tec_pkg::BOM_UTF8_TAIL) begin
					nxt.lead = 16'h0000;
				end
			end
			default: ;
		endcase
		if (cur.seen != 2'd3) begin
			nxt.seen = cur.seen + 2'd1;
		end

		// UTF-8 decode
		if (cur.cont != 2'd0) begin
			if (data_byte[7:6] != 2'b10) begin
				nxt.inv  = 1'b1;
				nxt.cont = 2'd0;
			end else begin
				nxt.acc  = acc_shift;
				nxt.cont = cont_dec;
				if (cont_dec == 2'd0) begin
					if (cur.seqlen == tec_pkg::SEQ_THREE &&
					    (acc_shift < tec_pkg::CP3_MIN ||
					     (acc_shift >= tec_pkg::SURR_LO && acc_shift <= tec_pkg::SURR_HI))) begin
						nxt.inv = 1'b1;
					end
					if (cur.seqlen == tec_pkg::SEQ_FOUR &&
					    (acc_shift < tec_pkg::CP4_MIN || acc_shift > tec_pkg::CP4_MAX)) begin
						nxt.inv = 1'b1;
					end
				end
			end
		end else if (data_byte[7] == 1'b0) begin
			// plain ASCII: nothing to track
		end else if (data_byte[7:5] == 3'b110) begin
			if (data_byte < tec_pkg::LEAD2_MIN) begin
				nxt.inv = 1'b1;
			end
			nxt.seqlen = tec_pkg::SEQ_TWO;
			nxt.cont   = tec_pkg::SEQ_TWO;
			nxt.acc    = {16'h0000, data_byte[4:0]};
		end else if (data_byte[7:4] == 4'b1110) begin
			nxt.seqlen = tec_pkg::SEQ_THREE;
			nxt.cont   = tec_pkg::SEQ_THREE;
			nxt.acc    = {17'h00000, data_byte[3:0]};
		end else if (data_byte[7:3] == 5'b11110) begin
			nxt.seqlen = tec_pkg::SEQ_FOUR;
			nxt.cont   = tec_pkg::SEQ_FOUR;
			nxt.acc    = {18'h00000, data_byte[2:0]};
		end else begin
			nxt.inv = 1'b1;
		end
	end

	// Classify on the updated state; marks take priority over validation.
	always_comb begin
		if (nxt.seen == 2'd3 && nxt.lead == tec_pkg::BOM_UTF8_HEAD) begin
			encoding_class = tec_pkg::CLS_UTF8_BOM;
		end else if (nxt.seen >= 2'd2 && nxt.lead == tec_pkg::BOM_U16LE) begin
			encoding_class = tec_pkg::CLS_U16LE;
		end else if (nxt.seen >= 2'd2 && nxt.lead == tec_pkg::BOM_U16BE) begin
			encoding_class = tec_pkg::CLS_U16BE;
		end else if (nxt.inv || nxt.cont != 2'd0) begin
			encoding_class = tec_pkg::CLS_OTHER;
		end else begin
			encoding_class = tec_pkg::CLS_UTF8;
		end
	end

endmodule

`default_nettype wire

### rtl/text_encoding_classifier_core.sv
// ----------------------------------------------------------------------------
// text_encoding_classifier_core
// Path: the last byte of a text passes the input register, then the result
// register, which holds its class valid. Throughput: one byte per cycle,
// sustained, set by the state update at the input register; a closing byte
// waits only while the previous class is held downstream.
// Reset: arst_n clears the decode state and both valid flags at once.
// ----------------------------------------------------------------------------
`default_nettype none

module text_encoding_classifier_core (
	input  wire  logic                               clk,
	input  wire  logic                               arst_n,
	input  wire  logic                               byte_valid,
	output logic                                     byte_stall,
	input  wire  logic [7:0]                         data_byte,
	input  wire  logic                               last_byte,
	output logic                                     class_valid,
	input  wire  logic                               class_stall,
	output logic [tec_pkg::ClassWidth-1:0]           encoding_class
);

	// Input register
	logic       vld_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	// Running decode state for the text in flight
	tec_pkg::tec_state_t state_q;
	tec_pkg::tec_state_t state_nxt;
	logic [tec_pkg::ClassWidth-1:0] cls_nxt;

	// Result register
	logic                           vld_s2;
	logic [tec_pkg::ClassWidth-1:0] cls_s2;

	logic adv_s1;
	logic take_in;

	// Advance the held byte unless it closes a text and the result register
	// is still full and stalled downstream.
	assign adv_s1     = vld_s1 && (!last_s1 || !vld_s2 || !class_stall);
	assign byte_stall = vld_s1 && !adv_s1;
	assign take_in    = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!byte_stall) begin
			vld_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	tec_step u_step (
		.cur            (state_q),
		.data_byte      (data_s1),
		.nxt            (state_nxt),
		.encoding_class (cls_nxt)
	);

	// Hold the state between bytes; drop it all once the last byte is done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			if (last_s1) begin
				state_q <= '0;
			end else begin
				state_q <= state_nxt;
			end
		end
	end

	// One transaction out per text, loaded when its last byte advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			vld_s2 <= 1'b1;
		end else if (!class_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			cls_s2 <= cls_nxt;
		end
	end

	assign class_valid    = vld_s2;
	assign encoding_class = cls_s2;

endmodule

`default_nettype wire

### tb/sv/text_class_model_pkg.sv
// ----------------------------------------------------------------------------
// text_class_model_pkg
// Scoreboard for the text encoding classifier: predicts the class of every
// text from the bytes taken and compares each class returned by the block.
// ----------------------------------------------------------------------------

package text_class_model_pkg;

	class text_class_predictor;

		logic [15:0]                    lead;
		logic [1:0]                     seen;
		logic [1:0]                     cont;
		logic [1:0]                     seqlen;
		logic [tec_pkg::AccWidth-1:0]   acc;
		logic                           inv;
		logic [tec_pkg::ClassWidth-1:0] pending_classes[$];
		int unsigned                    errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			lead   = 16'd0;
			seen   = 2'd0;
			cont   = 2'd0;
			seqlen = 2'd0;
			acc    = '0;
			inv    = 1'b0;
		endfunction

		function int unsigned pending();
			return pending_classes.size();
		endfunction

		task report(input string msg);
			errors++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		// Note one accepted byte; queue a class when it closes the text.
		function void take_byte(input logic [7:0] b, input logic fin);
			logic [tec_pkg::ClassWidth-1:0] cls;

			case (seen)
				2'd0: lead = {b, 8'h00};
				2'd1: lead[7:0] = b;
				2'd2: begin
					if (lead == tec_pkg::BOM_UTF8_HEAD && b != tec_pkg::BOM_UTF8_TAIL)
						lead = 16'd0;
				end
				default: ;
			endcase
			if (seen != 2'd3)
				seen = seen + 2'd1;

			if (cont != 2'd0) begin
				if (b[7:6] != 2'b10) begin
					inv  = 1'b1;
					cont = 2'd0;
				end else begin
					acc  = {acc[tec_pkg::AccWidth-7:0], b[5:0]};
					cont = cont - 2'd1;
					if (cont == 2'd0 && seqlen == tec_pkg::SEQ_THREE &&
					    (acc < tec_pkg::CP3_MIN ||
					     (acc >= tec_pkg::SURR_LO && acc <= tec_pkg::SURR_HI)))
						inv = 1'b1;
					if (cont == 2'd0 && seqlen == tec_pkg::SEQ_FOUR &&
					    (acc < tec_pkg::CP4_MIN || acc > tec_pkg::CP4_MAX))
						inv = 1'b1;
				end
			end else if (b[7]) begin
				casez (b)
					8'b110?????: begin
						if (b < tec_pkg::LEAD2_MIN)
							inv = 1'b1;
						seqlen = tec_pkg::SEQ_TWO;
						acc    = {16'd0, b[4:0]};
						cont   = tec_pkg::SEQ_TWO;
					end
					8'b1110????: begin
						seqlen = tec_pkg::SEQ_THREE;
						acc    = {17'd0, b[3:0]};
						cont   = tec_pkg::SEQ_THREE;
					end
					8'b11110???: begin
						seqlen = tec_pkg::SEQ_FOUR;
						acc    = {18'd0, b[2:0]};
						cont   = tec_pkg::SEQ_FOUR;
					end
					default: inv = 1'b1;
				endcase
			end

			if (!fin)
				return;

			if (seen == 2'd3 && lead == tec_pkg::BOM_UTF8_HEAD)
				cls = tec_pkg::CLS_UTF8_BOM;
			else if (seen >= 2'd2 && lead == tec_pkg::BOM_U16LE)
				cls = tec_pkg::CLS_U16LE;
			else if (seen >= 2'd2 && lead == tec_pkg::BOM_U16BE)
				cls = tec_pkg::CLS_U16BE;
			else if (inv || cont != 2'd0)
				cls = tec_pkg::CLS_OTHER;
			else
				cls = tec_pkg::CLS_UTF8;
			pending_classes = {pending_classes, cls};
			clear();
		endfunction

		task check_class(input logic [tec_pkg::ClassWidth-1:0] got);
			logic [tec_pkg::ClassWidth-1:0] want;

			if (pending_classes.size() == 0) begin
				report($sformatf("class %0d returned with no text outstanding", got));
			end else begin
				want = pending_classes.pop_front();
				if (got !== want)
					report($sformatf("encoding_class %0d, predicted %0d", got, want));
			end
		endtask

	endclass

endpackage

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for text_encoding_classifier_core: a directed set of byte-order
// marks and malformed sequences, then random texts that are mostly well-formed
// UTF-8, with marks, overlong forms, surrogates, out-of-range values, damaged
// and truncated texts mixed in. Both handshakes idle at random; one long
// receiver hold-off backs the block up. Every class is checked in order.
// ----------------------------------------------------------------------------

module tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TEXT_BYTES   = 2000;
	localparam int unsigned PRESSURE_AT  = 600;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned QUIET_FROM   = 1200;
	localparam int unsigned QUIET_TO     = 1500;
	localparam int unsigned IDLE_PERCENT = 18;
	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned DRAIN_CYCLES = 8;

	logic                           clk            = 1'b0;
	logic                           arst_n         = 1'b0;
	logic                           byte_valid     = 1'b0;
	logic                           byte_stall;
	logic [7:0]                     data_byte      = 8'h00;
	logic                           last_byte      = 1'b0;
	logic                           class_valid;
	logic                           class_stall    = 1'b0;
	logic [tec_pkg::ClassWidth-1:0] encoding_class;

	text_class_model_pkg::text_class_predictor sb = new();
	int unsigned           bytes_taken = 0;
	int unsigned           idle_cycles = 0;
	logic [7:0]            text_bytes[$];

	// Directed opening: bit 8 flags the last byte of each text.
	logic [8:0]            opening [0:25];

	// The stretch in which neither side idles.
	wire quiet = (bytes_taken >= QUIET_FROM) && (bytes_taken < QUIET_TO);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	text_encoding_classifier_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_valid     (byte_valid),
		.byte_stall     (byte_stall),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.class_valid    (class_valid),
		.class_stall    (class_stall),
		.encoding_class (encoding_class)
	);

	// Offer one byte, idling beforehand at random, and hold it until the
	// transaction completes. Call at a rising edge.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte  <= b;
		last_byte  <= fin;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		sb.take_byte(b, fin);
		bytes_taken++;
	endtask

	// Append one byte to the text under construction.
	task automatic add_byte(input logic [7:0] b);
		text_bytes = {text_bytes, b};
	endtask

	// Append a code point in the given byte length, with no check on range:
	// overlong, surrogate and out-of-range forms come out of here as well.
	task automatic push_code(input logic [20:0] cp, input int unsigned len);
		case (len)
			1: add_byte({1'b0, cp[6:0]});
			2: begin
				add_byte({3'b110, cp[10:6]});
				add_byte({2'b10, cp[5:0]});
			end
			3: begin
				add_byte({4'b1110, cp[15:12]});
				add_byte({2'b10, cp[11:6]});
				add_byte({2'b10, cp[5:0]});
			end
			default: begin
				add_byte({5'b11110, cp[20:18]});
				add_byte({2'b10, cp[17:12]});
				add_byte({2'b10, cp[11:6]});
				add_byte({2'b10, cp[5:0]});
			end
		endcase
	endtask

	// Build one random text in text_bytes.
	task automatic make_text();
		int unsigned style;
		int unsigned nchar;
		int unsigned kind;
		int unsigned len;
		int unsigned dmg;
		logic [20:0] cp;

		text_bytes.delete();
		style = $urandom_range(0, 99);

		// Mark prefixes: full ones, and UTF-8 mark heads that are mostly left partial.
		if (style < 10) begin
			add_byte(8'hEF);
			add_byte(8'hBB);
			add_byte(8'hBF);
		end else if (style < 15) begin
			add_byte(8'hFF);
			add_byte(8'hFE);
		end else if (style < 20) begin
			add_byte(8'hFE);
			add_byte(8'hFF);
		end else if (style < 25) begin
			add_byte(8'hEF);
			if ($urandom_range(0, 1))
				add_byte(8'hBB);
			if ($urandom_range(0, 1))
				add_byte(8'($urandom_range(0, 255)));
		end

		if (style >= 88) begin
			// Noise: raw bytes, lone continuations and illegal leads among them.
			nchar = $urandom_range(1, 6);
			for (int unsigned i = 0; i < nchar; i++)
				add_byte(8'($urandom_range(0, 255)));
		end else begin
			nchar = $urandom_range(0, 8);
			for (int unsigned i = 0; i < nchar; i++) begin
				kind = $urandom_range(0, 99);
				if (kind < 40) begin
					push_code(21'($urandom_range(0, 'h7F)), 1);
				end else if (kind < 60) begin
					push_code(21'($urandom_range('h80, 'h7FF)), 2);
				end else if (kind < 80) begin
					cp = 21'($urandom_range('h800, 'hFFFF));
					// Step clear of the surrogate range.
					if (cp >= tec_pkg::SURR_LO && cp <= tec_pkg::SURR_HI)
						cp = cp + 21'h800;
					push_code(cp, 3);
				end else if (kind < 92) begin
					push_code(21'($urandom_range('h10000, 'h10FFFF)), 4);
				end else if (kind < 94) begin
					len = $urandom_range(2, 4);
					cp = 21'($urandom_range(0, (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF));
					push_code(cp, len);
				end else if (kind < 96) begin
					push_code(21'($urandom_range('hD800, 'hDFFF)), 3);
				end else if (kind < 98) begin
					push_code(21'($urandom_range('h110000, 'h1FFFFF)), 4);
				end else begin
					add_byte(8'($urandom_range(0, 255)));
				end
			end
		end

		if (text_bytes.size() == 0)
			push_code(21'($urandom_range(0, 'h7F)), 1);

		// Damage a few texts: overwrite one byte, or cut the tail off.
		dmg = $urandom_range(0, 99);
		if (dmg < 8)
			text_bytes[$urandom_range(0, text_bytes.size() - 1)] = 8'($urandom_range(0, 255));
		else if (dmg < 14 && text_bytes.size() > 1)
			void'(text_bytes.pop_back());
	endtask

	// Sink: check each class taken, then choose the stall for the next cycle.
	// The long hold-off is counted here, while the source keeps offering bytes.
	initial begin : class_sink
		int unsigned hold_left;
		bit          pressure_done;

		hold_left     = 0;
		pressure_done = 1'b0;
		forever begin
			@(posedge clk);
			if (class_valid && !class_stall)
				sb.check_class(encoding_class);
			if (hold_left != 0) begin
				hold_left--;
				class_stall <= 1'b1;
			end else if (!pressure_done && bytes_taken >= PRESSURE_AT) begin
				pressure_done = 1'b1;
				hold_left     = HOLD_CYCLES;
				class_stall   <= 1'b1;
			end else begin
				class_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
			end
		end
	end

	// Watchdog: count cycles in which neither side moves a transaction.
	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (class_valid && !class_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : byte_source
		opening = '{
			9'h0EF, 9'h0BB, 9'h1BF,          // full UTF-8 mark
			9'h0EF, 9'h1BB,                  // mark cut short, truncated sequence
			9'h0FF, 9'h1FE,                  // UTF-16 LE mark
			9'h0FE, 9'h1FF,                  // UTF-16 BE mark
			9'h1FF,                          // one byte only, illegal lead
			9'h0C0, 9'h180,                  // overlong two-byte lead
			9'h0ED, 9'h0A0, 9'h180,          // surrogate
			9'h0F4, 9'h090, 9'h080, 9'h180,  // above the top code point
			9'h0E0, 9'h080, 9'h180,          // overlong three-byte form
			9'h0C3, 9'h141,                  // continuation missing
			9'h07F, 9'h100                   // plain ASCII, extremes
		};

		// Hold reset, then release it on an edge.
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;

		foreach (opening[i])
			send_byte(opening[i][7:0], opening[i][8]);

		while (bytes_taken < TEXT_BYTES) begin
			make_text();
			foreach (text_bytes[i])
				send_byte(text_bytes[i], i == text_bytes.size() - 1);
		end
		byte_valid <= 1'b0;

		// Drain outstanding classes, then allow for anything stray.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
rtl/tec_pkg.sv
rtl/tec_step.sv
rtl/text_encoding_classifier_core.sv
tb/sv/text_class_model_pkg.sv
tb/sv/tb.sv
